// File: design/dd_pkg.sv
package dd_pkg;

   // sizes of the tables
   localparam int NUM_PROCESSES = 8;
   localparam int NUM_RESOURCES = 4;
   localparam int COUNT_BITS    = 16;
   localparam int WORK_BITS     = COUNT_BITS + 3;
   localparam int PROC_IDX_BITS = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam int RES_IDX_BITS  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

   // request and response field widths
   localparam int CMD_BITS      = 2;
   localparam int PROC_IN_BITS  = 3;
   localparam int RES_IN_BITS   = 2;
   localparam int AMOUNT_BITS   = 16;
   localparam int MASK_BITS     = 8;

   // request command codes
   localparam logic [CMD_BITS-1:0] CMD_LOAD_ENTRY = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_LOAD_FREE  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_RUN        = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_entry;
      logic load_free;
      logic start_run;
      logic step;
      logic load_out;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic run_done;
   } dp_status_type;

endpackage

// File: design/dd_ctrl.sv
module dd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [dd_pkg::CMD_BITS-1:0] req_cmd,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   input  dd_pkg::dp_status_type       status,
   output dd_pkg::dp_cmd_type          cmd
);

   dd_pkg::state_type state_ff;
   dd_pkg::state_type state_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              req_fire;
   logic              slot_free;

   assign req_fire  = req_valid && (state_ff == dd_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dd_pkg::ST_IDLE: begin
            if (req_fire && (req_cmd == dd_pkg::CMD_RUN)) begin
               state_in = dd_pkg::ST_RUN;
            end
         end
         dd_pkg::ST_RUN: begin
            if (status.run_done) begin
               state_in = dd_pkg::ST_WAIT;
            end
         end
         dd_pkg::ST_WAIT: begin
            if (slot_free) begin
               state_in = dd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dd_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         dd_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_entry = req_fire && (req_cmd == dd_pkg::CMD_LOAD_ENTRY);
            cmd.load_free  = req_fire && (req_cmd == dd_pkg::CMD_LOAD_FREE);
            cmd.start_run  = req_fire && (req_cmd == dd_pkg::CMD_RUN);
         end
         dd_pkg::ST_RUN: begin
            cmd.step = 1'b1;
         end
         dd_pkg::ST_WAIT: begin
            cmd.load_out = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // no request is taken while a run walks the processes
   a_no_req_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dd_pkg::ST_RUN) |-> !req_ready)
      else $error("request taken during a run");

   // a run always ends by filling the response slot
   a_wait_fills: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dd_pkg::ST_WAIT) && slot_free |=> rsp_valid_ff && (state_ff == dd_pkg::ST_IDLE))
      else $error("run ended without a response");

   // a response is only produced after a run
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == dd_pkg::ST_WAIT))
      else $error("response without a run");

endmodule

// File: design/dd_datapath.sv
module dd_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  dd_pkg::dp_cmd_type             cmd,
   output dd_pkg::dp_status_type          status,
   input  logic [dd_pkg::PROC_IN_BITS-1:0] req_process_index,
   input  logic [dd_pkg::RES_IN_BITS-1:0]  req_resource_index,
   input  logic [dd_pkg::AMOUNT_BITS-1:0]  req_held_amount,
   input  logic [dd_pkg::AMOUNT_BITS-1:0]  req_wanted_amount,
   input  logic [dd_pkg::AMOUNT_BITS-1:0]  req_free_amount,
   output logic                           rsp_deadlock_found,
   output logic [dd_pkg::MASK_BITS-1:0]    rsp_stuck_mask
);

   localparam int NP = dd_pkg::NUM_PROCESSES;
   localparam int NR = dd_pkg::NUM_RESOURCES;
   localparam int CB = dd_pkg::COUNT_BITS;
   localparam int WB = dd_pkg::WORK_BITS;
   localparam int PB = dd_pkg::PROC_IDX_BITS;
   localparam int RB = dd_pkg::RES_IDX_BITS;
   localparam logic [PB-1:0] LAST_PROC = PB'(NP - 1);

   logic [CB-1:0] held_ff   [NP][NR];
   logic [CB-1:0] held_in   [NP][NR];
   logic [CB-1:0] wanted_ff [NP][NR];
   logic [CB-1:0] wanted_in [NP][NR];
   logic [CB-1:0] free_ff   [NR];
   logic [CB-1:0] free_in   [NR];
   logic [WB-1:0] work_ff   [NR];
   logic [WB-1:0] work_in   [NR];
   logic [NP-1:0] finished_ff;
   logic [NP-1:0] finished_in;
   logic [PB-1:0] proc_ff;
   logic [PB-1:0] proc_in;
   logic [PB-1:0] pass_ff;
   logic [PB-1:0] pass_in;
   logic          progress_ff;
   logic          progress_in;
   logic                       deadlock_ff;
   logic                       deadlock_in;
   logic [dd_pkg::MASK_BITS-1:0] mask_ff;
   logic [dd_pkg::MASK_BITS-1:0] mask_in;

   logic          entry_ok;
   logic          free_ok;
   logic [PB-1:0] load_proc;
   logic [RB-1:0] load_res;
   logic          fits;
   logic          release_now;
   logic          progress_now;
   logic          last_proc;
   logic          work_held_ok;

   // load addressing, loads outside the tables are dropped
   assign entry_ok  = (int'(req_process_index) < NP) && (int'(req_resource_index) < NR);
   assign free_ok   = int'(req_resource_index) < NR;
   assign load_proc = PB'(req_process_index);
   assign load_res  = RB'(req_resource_index);

   // table writes
   always_comb begin
      held_in   = held_ff;
      wanted_in = wanted_ff;
      free_in   = free_ff;
      if (cmd.load_entry && entry_ok) begin
         held_in[load_proc][load_res]   = CB'(req_held_amount);
         wanted_in[load_proc][load_res] = CB'(req_wanted_amount);
      end
      if (cmd.load_free && free_ok) begin
         free_in[load_res] = CB'(req_free_amount);
      end
   end

   // request of the current process against work, all resources at once
   always_comb begin
      fits = 1'b1;
      for (int r = 0; r < NR; r++) begin
         if (WB'(wanted_ff[proc_ff][r]) > work_ff[r]) begin
            fits = 1'b0;
         end
      end
   end

   assign release_now  = cmd.step && !finished_ff[proc_ff] && fits;
   assign progress_now = progress_ff || release_now;
   assign last_proc    = proc_ff == LAST_PROC;
   assign status.run_done = cmd.step && last_proc && (!progress_now || (pass_ff == LAST_PROC));

   // work vector: copy free at start, add held on release with saturation
   always_comb begin
      logic [WB:0] sum;
      sum = '0;
      work_in = work_ff;
      for (int r = 0; r < NR; r++) begin
         sum = {1'b0, work_ff[r]} + (WB + 1)'(held_ff[proc_ff][r]);
         if (cmd.start_run) begin
            work_in[r] = WB'(free_ff[r]);
         end else if (release_now) begin
            work_in[r] = sum[WB] ? {WB{1'b1}} : sum[WB-1:0];
         end
      end
   end

   // finished flags, process and pass counters
   always_comb begin
      finished_in = finished_ff;
      proc_in     = proc_ff;
      pass_in     = pass_ff;
      progress_in = progress_ff;
      if (cmd.start_run) begin
         finished_in = '0;
         proc_in     = '0;
         pass_in     = '0;
         progress_in = 1'b0;
      end else if (cmd.step) begin
         if (release_now) begin
            finished_in[proc_ff] = 1'b1;
         end
         if (last_proc) begin
            proc_in     = '0;
            pass_in     = (pass_ff == LAST_PROC) ? pass_ff : pass_ff + 1'b1;
            progress_in = 1'b0;
         end else begin
            proc_in     = proc_ff + 1'b1;
            progress_in = progress_now;
         end
      end
   end

   // response register
   always_comb begin
      mask_in     = mask_ff;
      deadlock_in = deadlock_ff;
      if (cmd.load_out) begin
         for (int i = 0; i < dd_pkg::MASK_BITS; i++) begin
            mask_in[i] = (i < NP) ? !finished_ff[i] : 1'b0;
         end
         deadlock_in = finished_ff != {NP{1'b1}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NP; p++) begin
            for (int r = 0; r < NR; r++) begin
               held_ff[p][r]   <= '0;
               wanted_ff[p][r] <= '0;
            end
         end
         for (int r = 0; r < NR; r++) begin
            free_ff[r] <= '0;
            work_ff[r] <= '0;
         end
         finished_ff <= '0;
         proc_ff     <= '0;
         pass_ff     <= '0;
         progress_ff <= 1'b0;
      end else begin
         held_ff     <= held_in;
         wanted_ff   <= wanted_in;
         free_ff     <= free_in;
         work_ff     <= work_in;
         finished_ff <= finished_in;
         proc_ff     <= proc_in;
         pass_ff     <= pass_in;
         progress_ff <= progress_in;
      end
   end

   always_ff @(posedge clock) begin
      deadlock_ff <= deadlock_in;
      mask_ff     <= mask_in;
   end

   assign rsp_deadlock_found = deadlock_ff;
   assign rsp_stuck_mask     = mask_ff;

   // work never shrinks while stepping
   always_comb begin
      work_held_ok = 1'b1;
      for (int r = 0; r < NR; r++) begin
         if (cmd.step && (work_in[r] < work_ff[r])) begin
            work_held_ok = 1'b0;
         end
      end
   end

   a_work_grows: assert property (@(posedge clock) disable iff (reset)
      work_held_ok)
      else $error("work vector shrank during a run");

   // a step never clears a finished flag
   a_finished_keep: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> ((finished_ff & $past(finished_ff)) == $past(finished_ff)))
      else $error("finished flag lost");

   // the deadlock flag agrees with the mask
   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (rsp_deadlock_found == (rsp_stuck_mask != '0)))
      else $error("deadlock flag and mask disagree");

endmodule

// File: design/deadlock_detector.sv
// load requests may follow back to back
// a run request walks one process per cycle: k passes of 8 processes, k from 1 to 8,
// after which its response is loaded into the output register once that register is free;
// the next request is taken once the response is in the output register
// synchronous active-high reset clears the held, wanted, free and work tables and the finished and response valid flags
module deadlock_detector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [dd_pkg::CMD_BITS-1:0]     req_cmd,
   input  logic [dd_pkg::PROC_IN_BITS-1:0] req_process_index,
   input  logic [dd_pkg::RES_IN_BITS-1:0]  req_resource_index,
   input  logic [dd_pkg::AMOUNT_BITS-1:0]  req_held_amount,
   input  logic [dd_pkg::AMOUNT_BITS-1:0]  req_wanted_amount,
   input  logic [dd_pkg::AMOUNT_BITS-1:0]  req_free_amount,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_deadlock_found,
   output logic [dd_pkg::MASK_BITS-1:0]    rsp_stuck_mask
);

   dd_pkg::dp_cmd_type    dp_cmd;
   dd_pkg::dp_status_type dp_status;

   // sequencer
   dd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // tables, work vector and response register
   dd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_process_index  (req_process_index),
      .req_resource_index (req_resource_index),
      .req_held_amount    (req_held_amount),
      .req_wanted_amount  (req_wanted_amount),
      .req_free_amount    (req_free_amount),
      .rsp_deadlock_found (rsp_deadlock_found),
      .rsp_stuck_mask     (rsp_stuck_mask)
   );

endmodule

// File: test/deadlock_detector_tb.sv
`timescale 1ns / 1ps

module deadlock_detector_tb;

   // cmd code that the block ignores
   localparam logic [dd_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS   = 1000;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int MAX_REPORTS    = 10;

   localparam logic [dd_pkg::WORK_BITS:0] WORK_MAX = {1'b0, {dd_pkg::WORK_BITS{1'b1}}};

   typedef logic [dd_pkg::AMOUNT_BITS-1:0]  amount_type;
   typedef logic [dd_pkg::PROC_IN_BITS-1:0] proc_type;
   typedef logic [dd_pkg::RES_IN_BITS-1:0]  res_type;
   typedef logic [dd_pkg::WORK_BITS-1:0]    work_type;

   typedef struct {
      logic [dd_pkg::CMD_BITS-1:0]     cmd;
      logic [dd_pkg::PROC_IN_BITS-1:0] proc_idx;
      logic [dd_pkg::RES_IN_BITS-1:0]  res_idx;
      logic [dd_pkg::AMOUNT_BITS-1:0]  held;
      logic [dd_pkg::AMOUNT_BITS-1:0]  wanted;
      logic [dd_pkg::AMOUNT_BITS-1:0]  avail;
      bit                              fixed;
      logic                            found;
      logic [dd_pkg::MASK_BITS-1:0]    mask;
   } request_type;

   typedef struct packed {
      logic                         found;
      logic [dd_pkg::MASK_BITS-1:0] mask;
   } verdict_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [dd_pkg::CMD_BITS-1:0]     req_cmd;
   logic [dd_pkg::PROC_IN_BITS-1:0] req_process_index;
   logic [dd_pkg::RES_IN_BITS-1:0]  req_resource_index;
   logic [dd_pkg::AMOUNT_BITS-1:0]  req_held_amount;
   logic [dd_pkg::AMOUNT_BITS-1:0]  req_wanted_amount;
   logic [dd_pkg::AMOUNT_BITS-1:0]  req_free_amount;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_deadlock_found;
   logic [dd_pkg::MASK_BITS-1:0] rsp_stuck_mask;

   // shadow copy of the allocation tables
   logic [dd_pkg::COUNT_BITS-1:0] held_units   [dd_pkg::NUM_PROCESSES][dd_pkg::NUM_RESOURCES];
   logic [dd_pkg::COUNT_BITS-1:0] wanted_units [dd_pkg::NUM_PROCESSES][dd_pkg::NUM_RESOURCES];
   logic [dd_pkg::COUNT_BITS-1:0] free_units   [dd_pkg::NUM_RESOURCES];

   verdict_type pending_verdicts[$];

   bit quiet = 1'b0;
   int errors = 0;
   int stalled_cycles = 0;
   int n_loads = 0;
   int n_runs = 0;
   int n_deadlocks = 0;
   int n_unused = 0;

   deadlock_detector u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_process_index  (req_process_index),
      .req_resource_index (req_resource_index),
      .req_held_amount    (req_held_amount),
      .req_wanted_amount  (req_wanted_amount),
      .req_free_amount    (req_free_amount),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_deadlock_found (rsp_deadlock_found),
      .rsp_stuck_mask     (rsp_stuck_mask)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void report_mismatch(input string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
   endfunction

   // mostly short gaps, a few long ones, none in quiet stretches
   function automatic int pick_gap(input int long_max);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, long_max);
   endfunction

   // small amounts dominate so that runs end both ways
   function automatic logic [dd_pkg::AMOUNT_BITS-1:0] rand_amount();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return amount_type'($urandom_range(0, 3));
      if (roll < 8) return amount_type'($urandom_range(0, 24));
      return amount_type'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic request_type make_req(input logic [dd_pkg::CMD_BITS-1:0] cmd,
                                            input logic [dd_pkg::PROC_IN_BITS-1:0] p,
                                            input logic [dd_pkg::RES_IN_BITS-1:0] r,
                                            input logic [dd_pkg::AMOUNT_BITS-1:0] h,
                                            input logic [dd_pkg::AMOUNT_BITS-1:0] w,
                                            input logic [dd_pkg::AMOUNT_BITS-1:0] f,
                                            input bit fixed,
                                            input logic found,
                                            input logic [dd_pkg::MASK_BITS-1:0] mask);
      request_type it;
      it.cmd = cmd;
      it.proc_idx = p;
      it.res_idx = r;
      it.held = h;
      it.wanted = w;
      it.avail = f;
      it.fixed = fixed;
      it.found = found;
      it.mask = mask;
      return it;
   endfunction

   // safety walk: finish every process whose requests fit, release its holdings
   function automatic verdict_type detect_deadlock();
      logic [dd_pkg::WORK_BITS-1:0] work [dd_pkg::NUM_RESOURCES];
      logic [dd_pkg::NUM_PROCESSES-1:0] finished;
      logic [dd_pkg::WORK_BITS:0] sum;
      logic progress, fits, settled;
      int pass, p, r;
      verdict_type v;
      for (r = 0; r < dd_pkg::NUM_RESOURCES; r++) work[r] = work_type'(free_units[r]);
      finished = '0;
      settled = 1'b0;
      for (pass = 0; pass < dd_pkg::NUM_PROCESSES && !settled; pass++) begin
         progress = 1'b0;
         for (p = 0; p < dd_pkg::NUM_PROCESSES; p++) begin
            if (!finished[p]) begin
               fits = 1'b1;
               for (r = 0; r < dd_pkg::NUM_RESOURCES; r++)
                  if (wanted_units[p][r] > work[r]) fits = 1'b0;
               if (fits) begin
                  for (r = 0; r < dd_pkg::NUM_RESOURCES; r++) begin
                     sum = work[r] + held_units[p][r];
                     work[r] = (sum > WORK_MAX) ? WORK_MAX[dd_pkg::WORK_BITS-1:0]
                                                : sum[dd_pkg::WORK_BITS-1:0];
                  end
                  finished[p] = 1'b1;
                  progress = 1'b1;
               end
            end
         end
         settled = !progress;
      end
      v.mask = ~finished[dd_pkg::MASK_BITS-1:0];
      v.found = |(~finished);
      return v;
   endfunction

   // update the shadow tables for one accepted request
   function automatic void apply_request(input request_type it);
      verdict_type v;
      case (it.cmd)
         dd_pkg::CMD_LOAD_ENTRY: begin
            held_units[it.proc_idx][it.res_idx] = it.held;
            wanted_units[it.proc_idx][it.res_idx] = it.wanted;
            n_loads++;
         end
         dd_pkg::CMD_LOAD_FREE: begin
            free_units[it.res_idx] = it.avail;
            n_loads++;
         end
         dd_pkg::CMD_RUN: begin
            v = detect_deadlock();
            if (it.fixed) begin
               v.found = it.found;
               v.mask = it.mask;
            end
            if (v.found) n_deadlocks++;
            n_runs++;
            pending_verdicts.push_back(v);
         end
         default: begin
            n_unused++;
         end
      endcase
   endfunction

   // present one request, optionally after all results are back
   task automatic drive_request(input request_type it, input bit drain_first);
      int gap;
      gap = pick_gap(30);
      if (gap > 0 || drain_first) begin
         req_valid <= 1'b0;
         @(posedge clock);
         repeat (gap) @(posedge clock);
         while (drain_first && pending_verdicts.size() != 0) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= it.cmd;
      req_process_index <= it.proc_idx;
      req_resource_index <= it.res_idx;
      req_held_amount <= it.held;
      req_wanted_amount <= it.wanted;
      req_free_amount <= it.avail;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_request(it);
   endtask

   // response side with random back-pressure
   initial begin : response_sink
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap(90);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // response checker and watchdog
   always @(posedge clock) begin : check_responses
      verdict_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("response with none pending: found %b mask %h",
                                         rsp_deadlock_found, rsp_stuck_mask));
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_deadlock_found !== want.found)
                  report_mismatch($sformatf("deadlock_found expected %b got %b",
                                            want.found, rsp_deadlock_found));
               if (rsp_stuck_mask !== want.mask)
                  report_mismatch($sformatf("stuck_mask expected %h got %h",
                                            want.mask, rsp_stuck_mask));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled_cycles = 0;
         else
            stalled_cycles++;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     stalled_cycles, pending_verdicts.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : stimulus
      request_type rows[$];
      request_type it;
      int i, k, n_items, n_batch, roll;
      bit drain;

      for (i = 0; i < dd_pkg::NUM_PROCESSES; i++)
         for (k = 0; k < dd_pkg::NUM_RESOURCES; k++) begin
            held_units[i][k] = '0;
            wanted_units[i][k] = '0;
         end
      for (k = 0; k < dd_pkg::NUM_RESOURCES; k++) free_units[k] = '0;

      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = dd_pkg::CMD_LOAD_ENTRY;
      req_process_index = '0;
      req_resource_index = '0;
      req_held_amount = '0;
      req_wanted_amount = '0;
      req_free_amount = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows: empty tables, extremes, ignored command, saturation, a cycle
      rows.push_back(make_req(dd_pkg::CMD_RUN, 0, 0, 0, 0, 0, 1, 1'b0, 8'h00));
      rows.push_back(make_req(dd_pkg::CMD_LOAD_ENTRY, 7, 3, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_RUN, 0, 0, 0, 0, 0, 1, 1'b1, 8'h80));
      rows.push_back(make_req(dd_pkg::CMD_LOAD_FREE, 0, 3, 0, 0, 16'hFFFF, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_RUN, 0, 0, 0, 0, 0, 1, 1'b0, 8'h00));
      rows.push_back(make_req(CMD_UNUSED, 7, 3, 0, 16'hFFFF, 0, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_RUN, 0, 0, 0, 0, 0, 1, 1'b0, 8'h00));
      rows.push_back(make_req(dd_pkg::CMD_LOAD_FREE, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
      for (i = 0; i < dd_pkg::NUM_PROCESSES - 1; i++)
         rows.push_back(make_req(dd_pkg::CMD_LOAD_ENTRY, proc_type'(i), 0, 16'hFFFF, 0,
                                 0, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_LOAD_ENTRY, 7, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_LOAD_ENTRY, 5, 1, 1, 0, 0, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_LOAD_ENTRY, 5, 2, 0, 1, 0, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_LOAD_ENTRY, 6, 2, 1, 0, 0, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_LOAD_ENTRY, 6, 1, 0, 1, 0, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_LOAD_FREE, 0, 2, 0, 0, 1, 0, 0, 0));
      rows.push_back(make_req(dd_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0, 0));

      foreach (rows[j]) drive_request(rows[j], 1'b0);

      // random batches of loads, ignored commands and runs, each closed by a run, first one after a full drain
      n_items = 0;
      drain = 1'b1;
      while (n_items < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 5) == 0);
         n_batch = $urandom_range(0, 12);
         for (k = 0; k <= n_batch; k++) begin
            it = make_req(dd_pkg::CMD_RUN, proc_type'($urandom_range(0, 7)),
                          res_type'($urandom_range(0, 3)),
                          rand_amount(), rand_amount(), rand_amount(), 0, 0, 0);
            roll = $urandom_range(0, 99);
            if (k < n_batch) begin
               if (roll < 65)
                  it.cmd = dd_pkg::CMD_LOAD_ENTRY;
               else if (roll < 92)
                  it.cmd = dd_pkg::CMD_LOAD_FREE;
               else if (roll < 96)
                  it.cmd = CMD_UNUSED;
            end else if ($urandom_range(0, 19) == 0) begin
               drain = 1'b1;
            end
            if (it.cmd != CMD_UNUSED) n_items++;
            drive_request(it, drain);
            drain = 1'b0;
         end
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d table loads, %0d ignored commands and %0d detection runs",
               n_loads, n_unused, n_runs);
      $display("%0d runs found a deadlock, %0d found every process able to finish",
               n_deadlocks, n_runs - n_deadlocks);
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results never arrived", errors,
                  pending_verdicts.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/dd_pkg.sv
design/dd_ctrl.sv
design/dd_datapath.sv
design/deadlock_detector.sv
test/deadlock_detector_tb.sv
